// File: hw/rtl/tbra_pkg.sv
// Shared types and constants of the transmit buffer ring allocator.
package tbra_pkg;

  localparam int ADDR_W  = 48;
  localparam int MAC_W   = 48;
  localparam int KIND_W  = 16;
  localparam int PAY_W   = 11;
  localparam int STAT_W  = 2;
  localparam int SLOT_W  = 6;
  localparam int FOFF_W  = 17;
  localparam int FLEN_W  = 12;
  localparam int CNT_W   = 7;
  localparam int NP_W    = 6;
  localparam int CFG_IDX_W = 2;

  // Size of the buffer pool; the slot index and the next pointer are sized for it.
  localparam int NUM_BUFFERS = 64;

  // Every buffer has the same power-of-two size.
  localparam int BUF_LG   = 11;
  localparam int BUF_SIZE = 1 << BUF_LG;
  localparam int HDR_BYTES = 14;

  localparam logic [CNT_W-1:0] COUNT_RESET = 7'd64;

  localparam logic [CFG_IDX_W-1:0] REG_OWN_MAC      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BUFFER_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REGION_BASE  = 2'd2;

  localparam logic CMD_ALLOC   = 1'b0;
  localparam logic CMD_RELEASE = 1'b1;

  localparam logic [STAT_W-1:0] STATUS_OK       = 2'd0;
  localparam logic [STAT_W-1:0] STATUS_NO_FREE  = 2'd1;
  localparam logic [STAT_W-1:0] STATUS_BAD_ADDR = 2'd2;

  typedef struct packed {
    logic              cmd;
    logic [MAC_W-1:0]  dest_mac;
    logic [KIND_W-1:0] frame_kind;
    logic [PAY_W-1:0]  payload_bytes;
    logic [ADDR_W-1:0] release_address;
  } in_item_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [SLOT_W-1:0] slot_index;
    logic [ADDR_W-1:0] payload_address;
    logic [MAC_W-1:0]  header_dest;
    logic [MAC_W-1:0]  header_source;
    logic [KIND_W-1:0] header_kind;
    logic [FOFF_W-1:0] frame_offset;
    logic [FLEN_W-1:0] frame_length;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PREP,
    ST_FIND,
    ST_DONE
  } ctl_state_t;

  typedef struct packed {
    logic load;
    logic prep;
    logic find;
    logic commit;
  } ctl_cmd_t;

endpackage

// File: hw/rtl/tbra_ctrl.sv
// Sequencer of the allocator: steps one request through the datapath and owns the result valid.
module tbra_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output tbra_pkg::ctl_cmd_t cmd
);

  tbra_pkg::ctl_state_t state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tbra_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    in_ready      = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      tbra_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = tbra_pkg::ST_PREP;
        end
      end
      tbra_pkg::ST_PREP: begin
        cmd.prep  = 1'b1;
        state_nxt = tbra_pkg::ST_FIND;
      end
      tbra_pkg::ST_FIND: begin
        cmd.find  = 1'b1;
        state_nxt = tbra_pkg::ST_DONE;
      end
      tbra_pkg::ST_DONE: begin
        // The result register must be empty or emptying before it is overwritten.
        if (!out_valid_r || out_ready) begin
          cmd.commit    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = tbra_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = tbra_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

// File: hw/rtl/tbra_datapath.sv
// Datapath of the allocator: registers, free map, circular search, address math and result.
module tbra_datapath #(
  parameter int MAP_N = 64,
  parameter int IDX_W = 6
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  tbra_pkg::ctl_cmd_t               cmd,
  input  logic                             cfg_we,
  input  logic [tbra_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [tbra_pkg::ADDR_W-1:0]      cfg_data,
  input  tbra_pkg::in_item_t               in_item,
  output tbra_pkg::out_item_t              out_item
);

  logic [tbra_pkg::MAC_W-1:0]  own_mac_r;
  logic [tbra_pkg::CNT_W-1:0]  buf_count_r;
  logic [tbra_pkg::ADDR_W-1:0] base_r;

  logic [MAP_N-1:0]            free_r, free_nxt;
  logic [tbra_pkg::NP_W-1:0]   np_r, np_nxt;

  tbra_pkg::in_item_t          item_r;
  logic [tbra_pkg::CNT_W-1:0]  count_r;
  logic [IDX_W-1:0]            start_r;
  logic [MAP_N-1:0]            m_hi_r, m_all_r;
  logic [tbra_pkg::ADDR_W-1:0] off_r;
  logic                        hit_r, ok_r;
  logic [IDX_W-1:0]            idx_r;
  tbra_pkg::out_item_t         out_r, out_nxt;

  logic [tbra_pkg::CNT_W-1:0]  count_eff;
  logic [tbra_pkg::CNT_W-1:0]  np_ext;
  logic [IDX_W-1:0]            start_c;
  logic [MAP_N-1:0]            m_hi_c, m_all_c, sel;
  logic [IDX_W-1:0]            f_idx;
  logic [tbra_pkg::CNT_W-1:0]  inc;
  logic [tbra_pkg::FLEN_W-1:0] len;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_mac_r   <= '0;
      buf_count_r <= tbra_pkg::COUNT_RESET;
      base_r      <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        tbra_pkg::REG_OWN_MAC:      own_mac_r   <= cfg_data;
        tbra_pkg::REG_BUFFER_COUNT: buf_count_r <= cfg_data[tbra_pkg::CNT_W-1:0];
        tbra_pkg::REG_REGION_BASE:  base_r      <= cfg_data;
        default: ;
      endcase
    end
  end

  // Allocator state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      free_r <= '1;
      np_r   <= '0;
    end else if (cmd.commit) begin
      free_r <= free_nxt;
      np_r   <= np_nxt;
    end
  end

  // Count clamped to the range 1 up to the map size.
  always_comb begin
    if (buf_count_r == '0) begin
      count_eff = tbra_pkg::CNT_W'(1);
    end else if (buf_count_r > tbra_pkg::CNT_W'(MAP_N)) begin
      count_eff = tbra_pkg::CNT_W'(MAP_N);
    end else begin
      count_eff = buf_count_r;
    end
  end

  // A stale next pointer restarts the search at buffer zero.
  assign np_ext  = tbra_pkg::CNT_W'(np_r);
  assign start_c = (np_ext >= count_eff) ? '0 : IDX_W'(np_ext);

  always_comb begin
    for (int i = 0; i < MAP_N; i++) begin
      m_all_c[i] = free_r[i] && (i < int'(count_eff));
      m_hi_c[i]  = m_all_c[i] && (i >= int'(start_c));
    end
  end

  // Free buffers at or after the start win; otherwise the search wraps.
  assign sel = (|m_hi_r) ? m_hi_r : m_all_r;

  always_comb begin
    f_idx = '0;
    for (int i = MAP_N - 1; i >= 0; i--) begin
      if (sel[i]) begin
        f_idx = IDX_W'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_r <= in_item;
    end
    if (cmd.prep) begin
      count_r <= count_eff;
      start_r <= start_c;
      m_hi_r  <= m_hi_c;
      m_all_r <= m_all_c;
      off_r   <= item_r.release_address - base_r - tbra_pkg::ADDR_W'(tbra_pkg::HDR_BYTES);
    end
    if (cmd.find) begin
      hit_r <= |sel;
      ok_r  <= off_r < (tbra_pkg::ADDR_W'(count_r) << tbra_pkg::BUF_LG);
      if (item_r.cmd == tbra_pkg::CMD_ALLOC) begin
        idx_r <= (|sel) ? f_idx : start_r;
      end else begin
        idx_r <= off_r[tbra_pkg::BUF_LG +: IDX_W];
      end
    end
    if (cmd.commit) begin
      out_r <= out_nxt;
    end
  end

  always_comb begin
    out_nxt  = '0;
    free_nxt = free_r;
    np_nxt   = np_r;
    inc      = tbra_pkg::CNT_W'(idx_r) + tbra_pkg::CNT_W'(1);
    len      = tbra_pkg::FLEN_W'(item_r.payload_bytes) + tbra_pkg::FLEN_W'(tbra_pkg::HDR_BYTES);
    if (inc == count_r) begin
      inc = '0;
    end
    if (len > tbra_pkg::FLEN_W'(tbra_pkg::BUF_SIZE)) begin
      len = tbra_pkg::FLEN_W'(tbra_pkg::BUF_SIZE);
    end
    if (item_r.cmd == tbra_pkg::CMD_ALLOC) begin
      np_nxt = inc[tbra_pkg::NP_W-1:0];
      if (hit_r) begin
        free_nxt[idx_r]         = 1'b0;
        out_nxt.status          = tbra_pkg::STATUS_OK;
        out_nxt.slot_index      = tbra_pkg::SLOT_W'(idx_r);
        out_nxt.payload_address = base_r
                                + ((tbra_pkg::ADDR_W'(idx_r) << tbra_pkg::BUF_LG)
                                   | tbra_pkg::ADDR_W'(tbra_pkg::HDR_BYTES));
        out_nxt.header_dest     = item_r.dest_mac;
        out_nxt.header_source   = own_mac_r;
        out_nxt.header_kind     = {item_r.frame_kind[7:0], item_r.frame_kind[15:8]};
      end else begin
        out_nxt.status = tbra_pkg::STATUS_NO_FREE;
      end
    end else begin
      if (ok_r) begin
        free_nxt[idx_r]      = 1'b1;
        out_nxt.status       = tbra_pkg::STATUS_OK;
        out_nxt.slot_index   = tbra_pkg::SLOT_W'(idx_r);
        out_nxt.frame_offset = off_r[tbra_pkg::FOFF_W-1:0];
        out_nxt.frame_length = len;
      end else begin
        out_nxt.status = tbra_pkg::STATUS_BAD_ADDR;
      end
    end
  end

  assign out_item = out_r;

endmodule

// File: hw/rtl/tx_buffer_ring_allocator_top.sv
// Top level of the transmit buffer ring allocator.
// The allocator hands out fixed-size transmit buffers of 2048 bytes from a pool and takes
// them back. An allocate request searches the free map circularly from the next pointer,
// claims the first free buffer and returns its index, its payload address (region base
// plus index times the buffer size plus the 14 header bytes) and the Ethernet header
// fields; the next pointer moves one past where the search stopped, even when every
// buffer is busy and status reports no free buffer. A release request maps a payload
// address back to its buffer, frees it and returns the descriptor offset and length, or
// reports an out-of-range address and leaves the pool alone. Each request passes through
// the states ST_IDLE, in which it is accepted, ST_PREP, which masks the free map and
// subtracts the region base, ST_FIND, which runs the find-first search across the free
// map and the range compare, and ST_DONE, which updates the pool and loads the result
// register. The block takes no new request until the previous one has been committed and
// it is back in ST_IDLE. A new request is accepted while the previous result still waits
// in the result register; the commit stalls only if that result has not been taken by
// then. The free map sits in flip-flops that reset sets to all free, so no clearing pass
// follows reset. The configuration port is always ready and must only be written while
// the block is idle. The pool holds the package's fixed number of buffers, 64, and
// buffer_count selects how many of them are in use.
module tx_buffer_ring_allocator_top (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  tbra_pkg::in_item_t             in_item,
  output logic                           out_valid,
  input  logic                           out_ready,
  output tbra_pkg::out_item_t            out_item,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [tbra_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tbra_pkg::ADDR_W-1:0]    cfg_data
);

  // The free map has one bit per buffer of the pool.
  localparam int MAP_N = tbra_pkg::NUM_BUFFERS;
  localparam int IDX_W = (MAP_N > 1) ? $clog2(MAP_N) : 1;

  tbra_pkg::ctl_cmd_t cmd;

  // Configuration writes never stall.
  assign cfg_ready = 1'b1;

  tbra_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  tbra_datapath #(
    .MAP_N (MAP_N),
    .IDX_W (IDX_W)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_item   (in_item),
    .out_item  (out_item)
  );

endmodule
